// ===== sv/hts_pkg.sv =====
// Shared types and constants for the harmonic tone synthesizer.
// Used by the controller, the datapath and the top level; depends on nothing.

package hts_pkg;

    // Datapath operation issued by the controller for one cycle.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_NOTE  = 4'd1,
        OP_START = 4'd2,
        OP_Z2    = 4'd3,
        OP_T     = 4'd4,
        OP_U     = 4'd5,
        OP_Y     = 4'd6,
        OP_W     = 4'd7,
        OP_AMP   = 4'd8,
        OP_F1    = 4'd9,
        OP_F2    = 4'd10,
        OP_ENV   = 4'd11
    } hts_op_t;

    typedef struct packed {
        hts_op_t    op;
        logic [1:0] harm;
    } hts_cmd_t;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_STEP_PER_HZ    = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS     = 2'd1;
    localparam logic [1:0] REG_DECAY_INTERVAL = 2'd2;
    localparam logic [1:0] REG_DECAY_STEPS    = 2'd3;

    localparam logic [31:0] RST_STEP_PER_HZ    = 32'd366503876;
    localparam logic [19:0] RST_HOLD_TICKS     = 20'd4800;
    localparam logic [15:0] RST_DECAY_INTERVAL = 16'd960;
    localparam logic [7:0]  RST_DECAY_STEPS    = 8'd100;

    // Envelope constants, amplitude in unsigned Q0.16.
    localparam logic [15:0] AMP_START = 16'd19661;
    localparam logic [15:0] AMP_FLOOR = 16'd66;
    localparam logic [15:0] DECAY_MUL = 16'd62259;

    // Sine polynomial z*(A - z^2*(B - z^2*C)), Q15 coefficients on a Q14 argument.
    localparam logic [15:0] COEF_A       = 16'd51472;
    localparam logic [15:0] COEF_B       = 16'd21024;
    localparam logic [11:0] COEF_C       = 12'd2320;
    localparam logic [14:0] SINE_QUARTER = 15'd16384;
    localparam logic [14:0] SINE_MAX     = 15'd32767;

    // Harmonic weights in Q15 for harmonics one to four.
    localparam logic [14:0] WEIGHT [4] = '{15'd19661, 15'd9830, 15'd4915, 15'd2621};

    // One-pole smoothing filter coefficients in Q15.
    localparam logic [14:0] FILT_NEW = 15'd22938;
    localparam logic [14:0] FILT_OLD = 15'd9830;

endpackage

// ===== sv/harmonic_tone_synth.sv =====
// Harmonic tone synthesizer top level: register file, controller and datapath.
// Depends on hts_pkg, hts_ctrl and hts_datapath.
//
// A note-on transfer (s_tuser high) sets the pitch from s_tdata and restarts the
// hold-then-decay envelope; it produces no output. A tick transfer (s_tuser low)
// produces one Q1.15 sample on the m_ side, with m_tuser flagging a silent
// sample. A silent tick runs only the envelope step; an audible tick sends
// all 24 products of the sample (five per harmonic for the sine polynomial and its
// weight, then amplitude, two filter terms and the decay) one per cycle through
// a single shared multiplier. The result register frees the input side as soon
// as the sample is loaded; a stalled result only holds the next tick at its
// final cycle.

module harmonic_tone_synth #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] note_freq, [23:20] zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tuser,   // [0] is_silent
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] step_per_hz_reg;
    logic [19:0] hold_ticks_reg;
    logic [15:0] decay_interval_reg;
    logic [7:0]  decay_steps_reg;
    logic        cfg_write;

    hts_pkg::hts_cmd_t cmd;
    logic              amp_low;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_per_hz_reg    <= hts_pkg::RST_STEP_PER_HZ;
            hold_ticks_reg     <= hts_pkg::RST_HOLD_TICKS;
            decay_interval_reg <= hts_pkg::RST_DECAY_INTERVAL;
            decay_steps_reg    <= hts_pkg::RST_DECAY_STEPS;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                hts_pkg::REG_STEP_PER_HZ:    step_per_hz_reg    <= pwdata;
                hts_pkg::REG_HOLD_TICKS:     hold_ticks_reg     <= pwdata[19:0];
                hts_pkg::REG_DECAY_INTERVAL: decay_interval_reg <= pwdata[15:0];
                hts_pkg::REG_DECAY_STEPS:    decay_steps_reg    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hts_pkg::REG_STEP_PER_HZ:    prdata = step_per_hz_reg;
            hts_pkg::REG_HOLD_TICKS:     prdata = {12'd0, hold_ticks_reg};
            hts_pkg::REG_DECAY_INTERVAL: prdata = {16'd0, decay_interval_reg};
            hts_pkg::REG_DECAY_STEPS:    prdata = {24'd0, decay_steps_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    hts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .amp_low  (amp_low),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hts_datapath #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .note_freq      (s_tdata[19:0]),
        .step_per_hz    (step_per_hz_reg),
        .hold_ticks     (hold_ticks_reg),
        .decay_interval (decay_interval_reg),
        .decay_steps    (decay_steps_reg),
        .amp_low        (amp_low),
        .sample_out     (m_tdata),
        .is_silent      (m_tuser)
    );

endmodule

// ===== sv/hts_datapath.sv =====
// Datapath of the harmonic tone synthesizer: oscillator and envelope state,
// one shared multiplier, sine polynomial, mixing, filter and output register.
// Depends on hts_pkg; driven by the commands of hts_ctrl.

module hts_datapath #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  hts_pkg::hts_cmd_t cmd,
    input  logic [19:0]      note_freq,
    input  logic [31:0]      step_per_hz,
    input  logic [19:0]      hold_ticks,
    input  logic [15:0]      decay_interval,
    input  logic [7:0]       decay_steps,
    output logic             amp_low,
    output logic [15:0]      sample_out,
    output logic             is_silent
);

    localparam int SINE_SHIFT = 16 - SINE_ADDR_BITS;

    // Oscillator and envelope state.
    logic [31:0] phase_acc_reg, phase_acc_next;
    logic [31:0] phase_step_reg, phase_step_next;
    logic [15:0] env_amp_reg, env_amp_next;
    logic [15:0] prev_out_reg, prev_out_next;
    logic [19:0] hold_left_reg, hold_left_next;
    logic [15:0] interval_left_reg, interval_left_next;
    logic [7:0]  steps_left_reg, steps_left_next;

    // Working registers of one sample computation.
    logic [14:0] z_reg, z_next;
    logic        neg_reg, neg_next;
    logic [14:0] z2_reg;
    logic [11:0] t_reg;
    logic [14:0] u_reg;
    logic [15:0] y_reg, y_next;
    logic [31:0] sum_reg, sum_next;
    logic [16:0] scaled_reg, scaled_next;
    logic [31:0] acc_reg;
    logic [15:0] out_sample_reg;
    logic        out_silent_reg;

    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] mul_p;

    logic [1:0]                hsel;
    logic [31:0]               harm_phase;
    logic [SINE_ADDR_BITS-1:0] sine_idx;
    logic [15:0]               sine_arg;
    logic [13:0]               sine_rem;

    logic [15:0] y_mag;
    logic [14:0] y_clamp;
    logic [32:0] mix_round;
    logic [16:0] mix;
    logic [33:0] amp_round;
    logic [32:0] filt_sum;
    logic [17:0] filt_y;
    logic [15:0] filt_sat;
    logic [32:0] decay_sum;
    logic [19:0] hold_dec;

    // Phase of the harmonic whose sine is fetched next, and its folded argument.
    assign hsel = (cmd.op == hts_pkg::OP_W) ? cmd.harm + 2'd1 : 2'd0;

    always_comb begin
        unique case (hsel)
            2'd0: harm_phase = phase_acc_reg;
            2'd1: harm_phase = phase_acc_reg << 1;
            2'd2: harm_phase = phase_acc_reg + (phase_acc_reg << 1);
            2'd3: harm_phase = phase_acc_reg << 2;
            default: harm_phase = phase_acc_reg;
        endcase
    end

    assign sine_idx = harm_phase[31 -: SINE_ADDR_BITS];
    assign sine_arg = {sine_idx, {SINE_SHIFT{1'b0}}};
    assign sine_rem = sine_arg[13:0];
    assign z_next   = sine_arg[14] ? hts_pkg::SINE_QUARTER - {1'b0, sine_rem}
                                   : {1'b0, sine_rem};
    assign neg_next = sine_arg[15];

    // Rounded mix of the harmonic sum, Q15.
    assign mix_round = {sum_reg[31], sum_reg} + 33'd16384;
    assign mix       = mix_round[31:15];

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            hts_pkg::OP_NOTE: begin
                mul_a = {1'b0, step_per_hz};
                mul_b = {1'b0, note_freq};
            end
            hts_pkg::OP_Z2: begin
                mul_a = {18'd0, z_reg};
                mul_b = {6'd0, z_reg};
            end
            hts_pkg::OP_T: begin
                mul_a = {18'd0, z2_reg};
                mul_b = {9'd0, hts_pkg::COEF_C};
            end
            hts_pkg::OP_U: begin
                mul_a = {18'd0, z2_reg};
                mul_b = {5'd0, hts_pkg::COEF_B - {4'd0, t_reg}};
            end
            hts_pkg::OP_Y: begin
                mul_a = {18'd0, z_reg};
                mul_b = {5'd0, hts_pkg::COEF_A - {1'b0, u_reg}};
            end
            hts_pkg::OP_W: begin
                mul_a = {{17{y_reg[15]}}, y_reg};
                mul_b = {6'd0, hts_pkg::WEIGHT[cmd.harm]};
            end
            hts_pkg::OP_AMP: begin
                mul_a = {{16{mix[16]}}, mix};
                mul_b = {5'd0, env_amp_reg};
            end
            hts_pkg::OP_F1: begin
                mul_a = {{16{scaled_reg[16]}}, scaled_reg};
                mul_b = {6'd0, hts_pkg::FILT_NEW};
            end
            hts_pkg::OP_F2: begin
                mul_a = {{17{prev_out_reg[15]}}, prev_out_reg};
                mul_b = {6'd0, hts_pkg::FILT_OLD};
            end
            hts_pkg::OP_ENV: begin
                mul_a = {17'd0, env_amp_reg};
                mul_b = {5'd0, hts_pkg::DECAY_MUL};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Sine value: clamp the magnitude, then apply the half-wave sign.
    assign y_mag   = mul_p[29:14];
    assign y_clamp = (y_mag > {1'b0, hts_pkg::SINE_MAX}) ? hts_pkg::SINE_MAX : y_mag[14:0];
    assign y_next  = neg_reg ? 16'd0 - {1'b0, y_clamp} : {1'b0, y_clamp};

    // The first harmonic starts a fresh sum.
    assign sum_next = ((cmd.harm == 2'd0) ? 32'd0 : sum_reg) + mul_p[31:0];

    assign amp_round   = mul_p[33:0] + 34'd32768;
    assign scaled_next = amp_round[32:16];

    // Filter output with rounding and saturation to Q1.15.
    assign filt_sum = {acc_reg[31], acc_reg} + {mul_p[31], mul_p[31:0]} + 33'd16384;
    assign filt_y   = filt_sum[32:15];

    always_comb begin
        if ($signed(filt_y) > 18'sd32767) begin
            filt_sat = 16'h7FFF;
        end else if ($signed(filt_y) < -18'sd32768) begin
            filt_sat = 16'h8000;
        end else begin
            filt_sat = filt_y[15:0];
        end
    end

    assign decay_sum = {1'b0, mul_p[31:0]} + 33'd32768;
    assign hold_dec  = (hold_left_reg != 20'd0) ? hold_left_reg - 20'd1 : hold_left_reg;
    assign amp_low   = env_amp_reg < hts_pkg::AMP_FLOOR;

    always_comb begin
        phase_acc_next     = phase_acc_reg;
        phase_step_next    = phase_step_reg;
        env_amp_next       = env_amp_reg;
        prev_out_next      = prev_out_reg;
        hold_left_next     = hold_left_reg;
        interval_left_next = interval_left_reg;
        steps_left_next    = steps_left_reg;
        unique case (cmd.op)
            hts_pkg::OP_NOTE: begin
                phase_step_next    = mul_p[47:16];
                env_amp_next       = hts_pkg::AMP_START;
                hold_left_next     = hold_ticks;
                steps_left_next    = decay_steps;
                interval_left_next = '0;
            end
            hts_pkg::OP_F2: begin
                prev_out_next  = filt_sat;
                phase_acc_next = phase_acc_reg + phase_step_reg;
            end
            hts_pkg::OP_ENV: begin
                hold_left_next = hold_dec;
                if (hold_dec == 20'd0 && steps_left_reg != 8'd0) begin
                    if (interval_left_reg == 16'd0) begin
                        env_amp_next       = decay_sum[31:16];
                        steps_left_next    = steps_left_reg - 8'd1;
                        // A zero interval behaves as an interval of one.
                        interval_left_next = (decay_interval != 16'd0) ?
                                             decay_interval - 16'd1 : 16'd0;
                    end else begin
                        interval_left_next = interval_left_reg - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg     <= '0;
            phase_step_reg    <= '0;
            env_amp_reg       <= '0;
            prev_out_reg      <= '0;
            hold_left_reg     <= '0;
            interval_left_reg <= '0;
            steps_left_reg    <= '0;
        end else begin
            phase_acc_reg     <= phase_acc_next;
            phase_step_reg    <= phase_step_next;
            env_amp_reg       <= env_amp_next;
            prev_out_reg      <= prev_out_next;
            hold_left_reg     <= hold_left_next;
            interval_left_reg <= interval_left_next;
            steps_left_reg    <= steps_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            hts_pkg::OP_START: begin
                z_reg   <= z_next;
                neg_reg <= neg_next;
            end
            hts_pkg::OP_Z2: z2_reg <= mul_p[28:14];
            hts_pkg::OP_T:  t_reg  <= mul_p[25:14];
            hts_pkg::OP_U:  u_reg  <= mul_p[28:14];
            hts_pkg::OP_Y:  y_reg  <= y_next;
            hts_pkg::OP_W: begin
                // The next harmonic's argument is fetched while this one is weighted.
                sum_reg <= sum_next;
                z_reg   <= z_next;
                neg_reg <= neg_next;
            end
            hts_pkg::OP_AMP: scaled_reg <= scaled_next;
            hts_pkg::OP_F1:  acc_reg    <= mul_p[31:0];
            hts_pkg::OP_ENV: begin
                out_sample_reg <= amp_low ? 16'd0 : prev_out_reg;
                out_silent_reg <= amp_low;
            end
            default: begin
            end
        endcase
    end

    assign sample_out = out_sample_reg;
    assign is_silent  = out_silent_reg;

endmodule

// ===== sv/hts_ctrl.sv =====
// Controller of the harmonic tone synthesizer: input and output handshakes
// and the sequence of datapath operations for one item. Depends on hts_pkg.

module hts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              req_type,
    output logic              s_tready,
    input  logic              amp_low,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hts_pkg::hts_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_Z2   = 10'b0000000010,
        S_T    = 10'b0000000100,
        S_U    = 10'b0000001000,
        S_Y    = 10'b0000010000,
        S_W    = 10'b0000100000,
        S_AMP  = 10'b0001000000,
        S_F1   = 10'b0010000000,
        S_F2   = 10'b0100000000,
        S_ENV  = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] harm_reg, harm_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        harm_next     = harm_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = hts_pkg::OP_NONE;
        cmd.harm      = harm_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (req_type) begin
                        cmd.op = hts_pkg::OP_NOTE;
                    end else if (amp_low) begin
                        state_next = S_ENV;
                    end else begin
                        cmd.op     = hts_pkg::OP_START;
                        harm_next  = 2'd0;
                        state_next = S_Z2;
                    end
                end
            end
            S_Z2: begin
                cmd.op     = hts_pkg::OP_Z2;
                state_next = S_T;
            end
            S_T: begin
                cmd.op     = hts_pkg::OP_T;
                state_next = S_U;
            end
            S_U: begin
                cmd.op     = hts_pkg::OP_U;
                state_next = S_Y;
            end
            S_Y: begin
                cmd.op     = hts_pkg::OP_Y;
                state_next = S_W;
            end
            S_W: begin
                cmd.op = hts_pkg::OP_W;
                if (harm_reg == 2'd3) begin
                    state_next = S_AMP;
                end else begin
                    harm_next  = harm_reg + 2'd1;
                    state_next = S_Z2;
                end
            end
            S_AMP: begin
                cmd.op     = hts_pkg::OP_AMP;
                state_next = S_F1;
            end
            S_F1: begin
                cmd.op     = hts_pkg::OP_F1;
                state_next = S_F2;
            end
            S_F2: begin
                cmd.op     = hts_pkg::OP_F2;
                state_next = S_ENV;
            end
            S_ENV: begin
                // The envelope advances in the same cycle the result is loaded,
                // so it waits until the output register is free.
                if (out_free) begin
                    cmd.op        = hts_pkg::OP_ENV;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            harm_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            harm_reg     <= harm_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== sv/hts_checker.sv =====
// Port-level checks for the harmonic tone synthesizer, bound to the top level.
// Depends only on the ports of harmonic_tone_synth.

module hts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A silent sample is always zero.
    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("silent sample is not zero");

    // A note-on transfer never causes a result.
    a_note_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !$rose(m_tvalid))
        else $error("result appeared after a note-on");

    // After a tick transfer the block is busy and the input side is not ready.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("input ready right after a tick transfer");

endmodule

bind harmonic_tone_synth hts_checker u_hts_checker (.*);
